/* hdl/resource_state_barrier_tracker_top_macros.svh */
// Assertion macros shared by the barrier tracker RTL.
`ifndef RESOURCE_STATE_BARRIER_TRACKER_TOP_MACROS_SVH
`define RESOURCE_STATE_BARRIER_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
`define RSBT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RSBT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSBT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RSBT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/rsbt_pkg.sv */
// Types, sizes and codes shared by the barrier tracker modules.
`timescale 1ns / 1ps
package rsbt_pkg;
   localparam int MAX_RESOURCES = 64;
   localparam int MAX_OVERRIDES = 16;
   localparam int SLOT_W = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
   localparam int JW = (MAX_OVERRIDES > 1) ? $clog2(MAX_OVERRIDES) : 1;
   localparam int CNT_W = $clog2(MAX_OVERRIDES + 1);
   localparam int OVA_W = (MAX_RESOURCES * MAX_OVERRIDES > 1) ?
                          $clog2(MAX_RESOURCES * MAX_OVERRIDES) : 1;

   typedef enum logic [1:0] {
      OP_TRANSITION = 2'd0,
      OP_UAV        = 2'd1,
      OP_ALIASING   = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_IMMEDIATE = 3'd0,
      KIND_PENDING   = 3'd1,
      KIND_UAV       = 3'd2,
      KIND_ALIASING  = 3'd3,
      KIND_ERROR     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE          = 2'd0,
      ERR_TABLE_FULL    = 2'd1,
      ERR_OVERRIDE_FULL = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      SEL_UAV,
      SEL_ALIAS,
      SEL_PENDING,
      SEL_ERR_TABLE,
      SEL_ERR_OVERRIDE,
      SEL_IMM_OVERRIDE,
      SEL_IMM_DEFAULT,
      SEL_IMM_SUB
   } sel_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] resource_id;
      logic [31:0] alias_after_id;
      logic        all_subs;
      logic [15:0] sub_index;
      logic [31:0] before_state;
      logic [31:0] after_state;
      logic [1:0]  barrier_flags;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] out_resource;
      logic [31:0] out_alias_after;
      logic        out_all_subs;
      logic [15:0] out_sub_index;
      logic [31:0] out_before;
      logic [31:0] out_after;
      logic [1:0]  out_flags;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    in_ready;
      logic    clear;
      logic    scan_start;
      logic    scan_run;
      logic    j_clr;
      logic    j_inc;
      logic    p1_chk;
      logic    emit;
      sel_type sel;
      logic    last;
      logic    wr_new;
      logic    wr_all;
      logic    wr_sub;
   } cmd_type;

   typedef struct packed {
      logic       in_valid;
      logic [1:0] in_op;
      logic [1:0] lat_op;
      logic       lat_all;
      logic       hit;
      logic       scan_end;
      logic       free_found;
      logic       cnt_zero;
      logic       cnt_full;
      logic       j_last;
      logic       ov_diff;
      logic       last_j_match;
      logic       found;
      logic       def_diff;
      logic       cur_diff;
      logic       out_free;
   } sts_type;
endpackage

/* hdl/rsbt_if.sv */
// Request and response channel interfaces of the barrier tracker.
`timescale 1ns / 1ps
interface rsbt_req_if import rsbt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rsbt_rsp_if import rsbt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* hdl/rsbt_datapath.sv */
// Datapath of the barrier tracker: tables, scan and override counters, result register.
`timescale 1ns / 1ps
module rsbt_datapath import rsbt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rsbt_req_if.sink   req_chan,
   rsbt_rsp_if.source rsp_chan,
   input  cmd_type cmd,
   output sts_type sts
);
   typedef struct packed {
      logic [31:0]      def;
      logic [CNT_W-1:0] cnt;
   } info_type;

   typedef struct packed {
      logic [15:0] idx;
      logic [31:0] st;
   } ov_type;

   logic [31:0] handle_mem [MAX_RESOURCES];
   info_type    info_mem [MAX_RESOURCES];
   ov_type      ov_mem [MAX_RESOURCES * MAX_OVERRIDES];

   req_type            lat_ff;
   logic [MAX_RESOURCES-1:0] valid_ff;
   logic [SLOT_W:0]    scan_idx_ff;
   logic [SLOT_W-1:0]  cmp_idx_ff;
   logic               cmp_vld_ff;
   logic [31:0]        handle_rd_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  free_ff;
   logic               free_found_ff;
   info_type           info_rd_ff;
   logic [JW-1:0]      j_ff;
   ov_type             ov_rd_ff;
   logic [JW-1:0]      last_j_ff;
   logic               found_ff;
   logic [JW-1:0]      found_j_ff;
   logic [31:0]        cur_ov_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               accept;
   logic               hit;
   logic [OVA_W-1:0]   ov_rd_addr;
   logic [OVA_W-1:0]   ov_wr_addr;
   logic [JW-1:0]      sub_j;
   logic               ov_we;
   logic               info_we;
   logic [SLOT_W-1:0]  info_wa;
   info_type           info_wd;
   logic [31:0]        cur_state;
   rsp_type            rsp_in;

   assign accept = req_chan.valid && cmd.in_ready;
   assign req_chan.ready = cmd.in_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;

   assign hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (handle_rd_ff == lat_ff.resource_id);
   assign sub_j = found_ff ? found_j_ff : info_rd_ff.cnt[JW-1:0];
   assign cur_state = found_ff ? cur_ov_ff : info_rd_ff.def;
   assign ov_rd_addr = OVA_W'(slot_ff) * OVA_W'(MAX_OVERRIDES) + OVA_W'(j_ff);
   assign ov_wr_addr = cmd.wr_new ? OVA_W'(free_ff) * OVA_W'(MAX_OVERRIDES) :
                       OVA_W'(slot_ff) * OVA_W'(MAX_OVERRIDES) + OVA_W'(sub_j);
   assign ov_we = (cmd.wr_new && !lat_ff.all_subs) || cmd.wr_sub;
   assign info_we = cmd.wr_new || cmd.wr_all || (cmd.wr_sub && !found_ff);
   assign info_wa = cmd.wr_new ? free_ff : slot_ff;

   always_comb begin
      if (cmd.wr_new) begin
         info_wd.def = lat_ff.all_subs ? lat_ff.after_state : 32'd0;
         info_wd.cnt = lat_ff.all_subs ? CNT_W'(0) : CNT_W'(1);
      end else if (cmd.wr_all) begin
         info_wd.def = lat_ff.after_state;
         info_wd.cnt = CNT_W'(0);
      end else begin
         info_wd.def = info_rd_ff.def;
         info_wd.cnt = info_rd_ff.cnt + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.out_resource = lat_ff.resource_id;
      rsp_in.out_flags = lat_ff.barrier_flags;
      rsp_in.last = cmd.last;
      unique case (cmd.sel)
         SEL_UAV: begin
            rsp_in.kind = KIND_UAV;
         end
         SEL_ALIAS: begin
            rsp_in.kind = KIND_ALIASING;
            rsp_in.out_alias_after = lat_ff.alias_after_id;
         end
         SEL_PENDING: begin
            rsp_in.kind = KIND_PENDING;
            rsp_in.out_all_subs = lat_ff.all_subs;
            rsp_in.out_sub_index = lat_ff.all_subs ? 16'd0 : lat_ff.sub_index;
            rsp_in.out_before = lat_ff.before_state;
            rsp_in.out_after = lat_ff.after_state;
         end
         SEL_ERR_TABLE: begin
            rsp_in.kind = KIND_ERROR;
            rsp_in.out_flags = 2'd0;
            rsp_in.error_code = ERR_TABLE_FULL;
         end
         SEL_ERR_OVERRIDE: begin
            rsp_in.kind = KIND_ERROR;
            rsp_in.out_flags = 2'd0;
            rsp_in.error_code = ERR_OVERRIDE_FULL;
         end
         SEL_IMM_OVERRIDE: begin
            rsp_in.kind = KIND_IMMEDIATE;
            rsp_in.out_sub_index = ov_rd_ff.idx;
            rsp_in.out_before = ov_rd_ff.st;
            rsp_in.out_after = lat_ff.after_state;
         end
         SEL_IMM_DEFAULT: begin
            rsp_in.kind = KIND_IMMEDIATE;
            rsp_in.out_all_subs = 1'b1;
            rsp_in.out_before = info_rd_ff.def;
            rsp_in.out_after = lat_ff.after_state;
         end
         SEL_IMM_SUB: begin
            rsp_in.kind = KIND_IMMEDIATE;
            rsp_in.out_sub_index = lat_ff.sub_index;
            rsp_in.out_before = cur_state;
            rsp_in.out_after = lat_ff.after_state;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      handle_rd_ff <= handle_mem[scan_idx_ff[SLOT_W-1:0]];
      if (cmd.wr_new) begin
         handle_mem[free_ff] <= lat_ff.resource_id;
      end
      info_rd_ff <= info_mem[slot_ff];
      if (info_we) begin
         info_mem[info_wa] <= info_wd;
      end
      ov_rd_ff <= ov_mem[ov_rd_addr];
      if (ov_we) begin
         ov_mem[ov_wr_addr] <= '{idx: lat_ff.sub_index, st: lat_ff.after_state};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cmp_vld_ff <= 1'b0;
         free_found_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.wr_new) begin
            valid_ff[free_ff] <= 1'b1;
         end
         cmp_vld_ff <= cmd.scan_run && (scan_idx_ff < (SLOT_W + 1)'(MAX_RESOURCES));
         if (cmd.scan_start) begin
            free_found_ff <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_run && cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
            if (cmd.p1_chk && (ov_rd_ff.idx == lat_ff.sub_index)) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lat_ff <= req_chan.data;
      end
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_run && (scan_idx_ff != (SLOT_W + 1)'(MAX_RESOURCES))) begin
         scan_idx_ff <= scan_idx_ff + (SLOT_W + 1)'(1);
      end
      cmp_idx_ff <= scan_idx_ff[SLOT_W-1:0];
      if (cmd.scan_run && hit) begin
         slot_ff <= cmp_idx_ff;
      end
      if (cmd.scan_run && cmp_vld_ff && !valid_ff[cmp_idx_ff] && !free_found_ff) begin
         free_ff <= cmp_idx_ff;
      end
      if (cmd.j_clr) begin
         j_ff <= '0;
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + JW'(1);
      end
      if (cmd.p1_chk) begin
         if (ov_rd_ff.st != lat_ff.after_state) begin
            last_j_ff <= j_ff;
         end
         if (ov_rd_ff.idx == lat_ff.sub_index) begin
            found_j_ff <= j_ff;
            cur_ov_ff <= ov_rd_ff.st;
         end
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.in_valid = req_chan.valid;
      sts.in_op = req_chan.data.op;
      sts.lat_op = lat_ff.op;
      sts.lat_all = lat_ff.all_subs;
      sts.hit = hit;
      sts.scan_end = cmp_vld_ff && (cmp_idx_ff == SLOT_W'(MAX_RESOURCES - 1));
      sts.free_found = free_found_ff;
      sts.cnt_zero = (info_rd_ff.cnt == CNT_W'(0));
      sts.cnt_full = (info_rd_ff.cnt >= CNT_W'(MAX_OVERRIDES));
      sts.j_last = ((CNT_W'({1'b0, j_ff}) + CNT_W'(1)) == info_rd_ff.cnt);
      sts.ov_diff = (ov_rd_ff.st != lat_ff.after_state);
      sts.last_j_match = (j_ff == last_j_ff);
      sts.found = found_ff;
      sts.def_diff = (info_rd_ff.def != lat_ff.after_state);
      sts.cur_diff = (cur_state != lat_ff.after_state);
      sts.out_free = !rsp_valid_ff || rsp_chan.ready;
   end
endmodule

/* hdl/rsbt_ctrl.sv */
// Sequencer of the barrier tracker: lookup, override passes, barrier emission, table update.
`timescale 1ns / 1ps
module rsbt_ctrl import rsbt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [3:0] {
      S_IDLE,
      S_PASS,
      S_SCAN,
      S_MISS,
      S_INFO_WAIT,
      S_DECIDE,
      S_P1_RD,
      S_P1_CHK,
      S_P2_RD,
      S_P2_CHK,
      S_ALL_DEF,
      S_SUB
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd = '0;
      cmd.sel = SEL_UAV;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            if (sts.in_valid) begin
               priority case (sts.in_op)
                  OP_CLEAR: cmd.clear = 1'b1;
                  OP_UAV, OP_ALIASING: state_in = S_PASS;
                  default: begin
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_PASS: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.sel = (sts.lat_op == OP_UAV) ? SEL_UAV : SEL_ALIAS;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.hit) begin
               state_in = S_INFO_WAIT;
            end else if (sts.scan_end) begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.sel = sts.free_found ? SEL_PENDING : SEL_ERR_TABLE;
               cmd.wr_new = sts.free_found;
               state_in = S_IDLE;
            end
         end
         S_INFO_WAIT: begin
            cmd.j_clr = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!sts.cnt_zero) begin
               state_in = S_P1_RD;
            end else if (sts.lat_all) begin
               state_in = S_ALL_DEF;
            end else begin
               state_in = S_SUB;
            end
         end
         S_P1_RD: state_in = S_P1_CHK;
         S_P1_CHK: begin
            cmd.p1_chk = 1'b1;
            if (sts.j_last) begin
               cmd.j_clr = 1'b1;
               state_in = sts.lat_all ? S_P2_RD : S_SUB;
            end else begin
               cmd.j_inc = 1'b1;
               state_in = S_P1_RD;
            end
         end
         S_P2_RD: state_in = S_P2_CHK;
         S_P2_CHK: begin
            if (!sts.ov_diff || sts.out_free) begin
               cmd.emit = sts.ov_diff;
               cmd.sel = SEL_IMM_OVERRIDE;
               cmd.last = sts.last_j_match;
               if (sts.j_last) begin
                  cmd.wr_all = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.j_inc = 1'b1;
                  state_in = S_P2_RD;
               end
            end
         end
         S_ALL_DEF: begin
            if (!sts.def_diff || sts.out_free) begin
               cmd.emit = sts.def_diff;
               cmd.sel = SEL_IMM_DEFAULT;
               cmd.last = 1'b1;
               cmd.wr_all = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SUB: begin
            if (!sts.found && sts.cnt_full) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.sel = SEL_ERR_OVERRIDE;
                  cmd.last = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (!sts.cur_diff || sts.out_free) begin
               cmd.emit = sts.cur_diff;
               cmd.sel = SEL_IMM_SUB;
               cmd.last = 1'b1;
               cmd.wr_sub = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* hdl/resource_state_barrier_tracker_top.sv */
// Top level of the resource state barrier tracker.
`timescale 1ns / 1ps
`include "resource_state_barrier_tracker_top_macros.svh"
// The block takes one request beat at a time and gives its barriers as response beats, the
// final one marked by last. UAV and aliasing requests give one response beat from S_PASS, and
// a clear is carried out in S_IDLE with no response. A transition first scans the handle
// table one entry per cycle through its memory read port, stopping at the first match; a hit
// then reads the entry's info and, if it has overrides, makes one pass over the override
// memory for a single subresource and two for a whole resource, then emits and updates.
// Response backpressure adds its stall cycles. Reset and the clear request empty the table
// at once through per-entry valid bits; no sweep is needed.
module resource_state_barrier_tracker_top import rsbt_pkg::*; (
   input logic clock,
   input logic reset,
   rsbt_req_if.sink   req_chan,
   rsbt_rsp_if.source rsp_chan
);
   cmd_type cmd;
   sts_type sts;
   logic    tbl_upd;

   assign tbl_upd = cmd.wr_new || cmd.wr_all || cmd.wr_sub;

   rsbt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   rsbt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .sts      (sts)
   );

   `RSBT_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, sts.out_free, "result overwritten")
   `RSBT_ASSERT_IMP(a_new_slot, clock, reset, cmd.wr_new, sts.free_found, "entry without slot")
   `RSBT_ASSERT_NXT(a_upd_idle, clock, reset, tbl_upd, cmd.in_ready, "not idle after update")
endmodule
